// ===== rtl/stps_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse tiled pixel store package
// Shared constants, register and request codes, item types and the command
// and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package stps_pkg;

  localparam int unsigned MAX_WIDTH   = 256;
  localparam int unsigned MAX_HEIGHT  = 256;
  localparam int unsigned MAX_TILES   = 1024;
  localparam int unsigned POOL_PIXELS = 131072;
  localparam int unsigned EDGE_MIN    = 8;
  localparam int unsigned EDGE_MAX    = 32;

  localparam int unsigned DIM_W   = 9;
  localparam int unsigned EDGE_W  = 6;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned RES_W   = 11;
  localparam int unsigned REV_W   = 32;
  localparam int unsigned EPOCH_W = 8;

  localparam int unsigned TILE_AW = $clog2(MAX_TILES);
  localparam int unsigned POOL_AW = $clog2(POOL_PIXELS);

  localparam int unsigned DIVD_W = DIM_W;
  localparam int unsigned DIVS_W = EDGE_W;
  localparam int unsigned DCNT_W = $clog2(DIVD_W + 1);

  localparam int unsigned QT_W    = $clog2((1 << COORD_W) / EDGE_MIN);
  localparam int unsigned COLS_W  = $clog2((MAX_WIDTH + EDGE_MAX - 1) / EDGE_MIN + 1);
  localparam int unsigned REM_W   = $clog2(EDGE_MAX);
  localparam int unsigned T_W     = QT_W + COLS_W + 1;
  localparam int unsigned ESQ_W   = $clog2(EDGE_MAX * EDGE_MAX + 1);
  localparam int unsigned OFF_W   = $clog2(EDGE_MAX * EDGE_MAX);
  localparam int unsigned BASE_W  = T_W + ESQ_W;
  localparam int unsigned SWEEP_W = (TILE_AW > OFF_W) ? TILE_AW : OFF_W;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_EDGE   = 2'd2
  } stps_reg_e;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_CLEAR = 2'd2
  } stps_req_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   pixel_value;
  } stps_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] read_data;
    logic             in_range;
    logic [9:0]       tile_number;
    logic             newly_allocated;
    logic             newly_dirty;
    logic [RES_W-1:0] resident_tiles;
    logic [REV_W-1:0] revision_count;
  } stps_out_t;

  typedef struct packed {
    logic load;
    logic mul_tile;
    logic mul_base;
    logic check;
    logic look;
    logic fill_step;
    logic tab_step;
    logic tab_present;
    logic commit;
    logic epoch_adv;
    logic epoch_restart;
    logic out_load;
  } stps_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic req_rw;
    logic req_write;
    logic req_clear;
    logic hit_ok;
    logic present;
    logic fill_last;
    logic tab_last;
    logic epoch_full;
    logic out_free;
  } stps_sts_t;

endpackage

// ===== rtl/stps_div.sv =====
// ----------------------------------------------------------------------------
// Sparse tiled pixel store divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stps_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [stps_pkg::DIVD_W-1:0] dividend_i,
  input  logic [stps_pkg::DIVS_W-1:0] divisor_i,
  output logic                        busy_o,
  output logic [stps_pkg::DIVD_W-1:0] quotient_o,
  output logic [stps_pkg::DIVS_W-1:0] remainder_o
);

  logic                        busy_q;
  logic [stps_pkg::DCNT_W-1:0] cnt_q;
  logic [stps_pkg::DIVD_W-1:0] quo_q;
  logic [stps_pkg::DIVS_W-1:0] rem_q;
  logic [stps_pkg::DIVS_W-1:0] dvs_q;
  logic [stps_pkg::DIVS_W:0]   shifted;
  logic [stps_pkg::DIVS_W+1:0] diff;
  logic                        ge;

  assign shifted = {rem_q, quo_q[stps_pkg::DIVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = ~diff[stps_pkg::DIVS_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= stps_pkg::DCNT_W'(stps_pkg::DIVD_W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - stps_pkg::DCNT_W'(1);
      busy_q <= (cnt_q != stps_pkg::DCNT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[stps_pkg::DIVD_W-2:0], ge};
      rem_q <= ge ? diff[stps_pkg::DIVS_W-1:0] : shifted[stps_pkg::DIVS_W-1:0];
    end
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== rtl/stps_datapath.sv =====
// ----------------------------------------------------------------------------
// Sparse tiled pixel store datapath
// Configuration registers, coordinate dividers, address arithmetic, the pixel
// pool, the tile present and dirty tables, counters and the output register.
// ----------------------------------------------------------------------------
module stps_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stps_pkg::stps_cmd_t   cmd_i,
  output stps_pkg::stps_sts_t   sts_o,
  input  stps_pkg::stps_in_t    in_data_i,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [stps_pkg::DIM_W-1:0] cfg_wdata_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output stps_pkg::stps_out_t   out_data_o
);

  // Dirty marks hold the epoch in which the tile was last written.
  logic [stps_pkg::PIX_W-1:0]   pix_mem     [stps_pkg::POOL_PIXELS];
  logic                         present_mem [stps_pkg::MAX_TILES];
  logic [stps_pkg::EPOCH_W-1:0] mark_mem    [stps_pkg::MAX_TILES];

  logic [stps_pkg::DIM_W-1:0]  cfg_w_q, cfg_h_q;
  logic [stps_pkg::EDGE_W-1:0] cfg_e_q;

  logic [stps_pkg::DIM_W-1:0]    w_sat, h_sat, cols_dvd;
  logic [stps_pkg::EDGE_W-1:0]   e_sat;
  logic [2*stps_pkg::EDGE_W-1:0] esq_full;

  logic [1:0]                   req_q;
  logic [stps_pkg::PIX_W-1:0]   val_q;
  logic                         inr_q;
  logic [stps_pkg::EDGE_W-1:0]  e_q;
  logic [stps_pkg::ESQ_W-1:0]   esq_q;
  logic [stps_pkg::T_W-1:0]     t_q;
  logic [stps_pkg::OFF_W-1:0]   off_q;
  logic [stps_pkg::BASE_W-1:0]  base_q;
  logic [stps_pkg::POOL_AW-1:0] addr_q;
  logic                         ok_q;
  logic                         present_rd_q;
  logic [stps_pkg::EPOCH_W-1:0] mark_rd_q;
  logic [stps_pkg::PIX_W-1:0]   pix_rd_q;
  logic                         alloc_q, ndirty_q;

  logic [stps_pkg::SWEEP_W-1:0] sweep_q;
  logic [stps_pkg::EPOCH_W-1:0] epoch_q;
  logic [stps_pkg::RES_W-1:0]   resident_q;
  logic [stps_pkg::REV_W-1:0]   revision_q;
  logic                         out_valid_q;
  stps_pkg::stps_out_t          out_data_q;

  logic                         bx, by, bc;
  logic [stps_pkg::DIVD_W-1:0]  qx, qy, qc;
  logic [stps_pkg::DIVS_W-1:0]  rx, ry, rc;

  logic [stps_pkg::T_W-1:0]      t_d;
  logic [stps_pkg::OFF_W-1:0]    off_d;
  logic [stps_pkg::BASE_W:0]     span_end;
  logic [stps_pkg::BASE_W-1:0]   addr_full, fill_full;
  logic [stps_pkg::TILE_AW-1:0]  tidx;
  logic                          tab_last, fill_last, is_rw, is_read;
  stps_pkg::stps_out_t           out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= stps_pkg::DIM_W'(256);
      cfg_h_q <= stps_pkg::DIM_W'(256);
      cfg_e_q <= stps_pkg::EDGE_W'(16);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        stps_pkg::REG_WIDTH:  cfg_w_q <= cfg_wdata_i;
        stps_pkg::REG_HEIGHT: cfg_h_q <= cfg_wdata_i;
        stps_pkg::REG_EDGE:   cfg_e_q <= cfg_wdata_i[stps_pkg::EDGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_sat = (cfg_w_q > stps_pkg::DIM_W'(stps_pkg::MAX_WIDTH)) ?
            stps_pkg::DIM_W'(stps_pkg::MAX_WIDTH) : cfg_w_q;
    h_sat = (cfg_h_q > stps_pkg::DIM_W'(stps_pkg::MAX_HEIGHT)) ?
            stps_pkg::DIM_W'(stps_pkg::MAX_HEIGHT) : cfg_h_q;
    if (cfg_e_q < stps_pkg::EDGE_W'(stps_pkg::EDGE_MIN)) begin
      e_sat = stps_pkg::EDGE_W'(stps_pkg::EDGE_MIN);
    end else if (cfg_e_q > stps_pkg::EDGE_W'(stps_pkg::EDGE_MAX)) begin
      e_sat = stps_pkg::EDGE_W'(stps_pkg::EDGE_MAX);
    end else begin
      e_sat = cfg_e_q;
    end
    cols_dvd = w_sat + stps_pkg::DIM_W'(e_sat) - stps_pkg::DIM_W'(1);
    esq_full = {{stps_pkg::EDGE_W{1'b0}}, e_sat} * {{stps_pkg::EDGE_W{1'b0}}, e_sat};
  end

  stps_div u_div_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.load),
    .dividend_i  ({1'b0, in_data_i.x}),
    .divisor_i   (e_sat),
    .busy_o      (bx),
    .quotient_o  (qx),
    .remainder_o (rx)
  );

  stps_div u_div_y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.load),
    .dividend_i  ({1'b0, in_data_i.y}),
    .divisor_i   (e_sat),
    .busy_o      (by),
    .quotient_o  (qy),
    .remainder_o (ry)
  );

  stps_div u_div_cols (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.load),
    .dividend_i  (cols_dvd),
    .divisor_i   (e_sat),
    .busy_o      (bc),
    .quotient_o  (qc),
    .remainder_o (rc)
  );

  always_comb begin
    t_d   = stps_pkg::T_W'(qy[stps_pkg::QT_W-1:0]) * stps_pkg::T_W'(qc[stps_pkg::COLS_W-1:0])
          + stps_pkg::T_W'(qx[stps_pkg::QT_W-1:0]);
    off_d = stps_pkg::OFF_W'(ry[stps_pkg::REM_W-1:0]) * stps_pkg::OFF_W'(e_q)
          + stps_pkg::OFF_W'(rx[stps_pkg::REM_W-1:0]);
    span_end  = (stps_pkg::BASE_W+1)'(base_q) + (stps_pkg::BASE_W+1)'(esq_q);
    addr_full = base_q + stps_pkg::BASE_W'(off_q);
    fill_full = base_q + stps_pkg::BASE_W'(sweep_q);
    tidx      = t_q[stps_pkg::TILE_AW-1:0];
    tab_last  = (sweep_q == stps_pkg::SWEEP_W'(stps_pkg::MAX_TILES - 1));
    fill_last = ((stps_pkg::ESQ_W'(sweep_q) + stps_pkg::ESQ_W'(1)) == esq_q);
    is_read   = (req_q == stps_pkg::REQ_READ);
    is_rw     = is_read || (req_q == stps_pkg::REQ_WRITE);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i.req_type;
      val_q <= in_data_i.pixel_value;
      inr_q <= ({1'b0, in_data_i.x} < w_sat) && ({1'b0, in_data_i.y} < h_sat);
      e_q   <= e_sat;
      esq_q <= esq_full[stps_pkg::ESQ_W-1:0];
    end
    if (cmd_i.mul_tile) begin
      t_q   <= t_d;
      off_q <= off_d;
    end
    if (cmd_i.mul_base) begin
      base_q <= stps_pkg::BASE_W'(t_q) * stps_pkg::BASE_W'(esq_q);
    end
    if (cmd_i.check) begin
      ok_q   <= inr_q && (t_q < stps_pkg::T_W'(stps_pkg::MAX_TILES)) &&
                (span_end <= (stps_pkg::BASE_W+1)'(stps_pkg::POOL_PIXELS));
      addr_q <= addr_full[stps_pkg::POOL_AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_step) begin
      pix_mem[fill_full[stps_pkg::POOL_AW-1:0]] <= '0;
    end else if (cmd_i.commit) begin
      pix_mem[addr_q] <= val_q;
    end
    if (cmd_i.look) begin
      pix_rd_q <= pix_mem[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tab_step) begin
      mark_mem[sweep_q[stps_pkg::TILE_AW-1:0]] <= '0;
      if (cmd_i.tab_present) begin
        present_mem[sweep_q[stps_pkg::TILE_AW-1:0]] <= 1'b0;
      end
    end else if (cmd_i.commit) begin
      present_mem[tidx] <= 1'b1;
      mark_mem[tidx]    <= epoch_q;
    end
    if (cmd_i.check) begin
      present_rd_q <= present_mem[tidx];
      mark_rd_q    <= mark_mem[tidx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q    <= '0;
      epoch_q    <= stps_pkg::EPOCH_W'(1);
      resident_q <= '0;
      revision_q <= '0;
      alloc_q    <= 1'b0;
      ndirty_q   <= 1'b0;
    end else begin
      if (cmd_i.tab_step) begin
        sweep_q <= tab_last ? '0 : sweep_q + stps_pkg::SWEEP_W'(1);
      end else if (cmd_i.fill_step) begin
        sweep_q <= fill_last ? '0 : sweep_q + stps_pkg::SWEEP_W'(1);
      end
      if (cmd_i.epoch_restart) begin
        epoch_q <= stps_pkg::EPOCH_W'(1);
      end else if (cmd_i.epoch_adv) begin
        epoch_q <= epoch_q + stps_pkg::EPOCH_W'(1);
      end
      if (cmd_i.load) begin
        alloc_q  <= 1'b0;
        ndirty_q <= 1'b0;
      end else if (cmd_i.commit) begin
        alloc_q    <= ~present_rd_q;
        ndirty_q   <= (mark_rd_q != epoch_q);
        revision_q <= revision_q + stps_pkg::REV_W'(1);
        if (!present_rd_q) begin
          resident_q <= resident_q + stps_pkg::RES_W'(1);
        end
      end
    end
  end

  always_comb begin
    out_d.read_data       = (is_read && ok_q && present_rd_q) ? pix_rd_q : '0;
    out_d.in_range        = is_rw && ok_q;
    out_d.tile_number     = (is_rw && ok_q) ? tidx : '0;
    out_d.newly_allocated = alloc_q;
    out_d.newly_dirty     = ndirty_q;
    out_d.resident_tiles  = resident_q;
    out_d.revision_count  = revision_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= out_d;
    end
  end

  always_comb begin
    sts_o.div_busy   = bx | by | bc | (|rc[0]) & 1'b0;
    sts_o.req_rw     = is_rw;
    sts_o.req_write  = (req_q == stps_pkg::REQ_WRITE);
    sts_o.req_clear  = (req_q == stps_pkg::REQ_CLEAR);
    sts_o.hit_ok     = ok_q;
    sts_o.present    = present_rd_q;
    sts_o.fill_last  = fill_last;
    sts_o.tab_last   = tab_last;
    sts_o.epoch_full = &epoch_q;
    sts_o.out_free   = ~out_valid_q | out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/stps_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sparse tiled pixel store controller
// Sequences the table clear after reset, the address computation, tile
// zero-fill, the commit of a write, dirty clearing and result delivery.
// ----------------------------------------------------------------------------
module stps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  stps_pkg::stps_sts_t sts_i,
  output stps_pkg::stps_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_TABCLR,
    S_IDLE,
    S_DIV,
    S_MULT,
    S_MULB,
    S_CHECK,
    S_LOOK,
    S_FILL,
    S_COMMIT,
    S_EPOCH,
    S_MARKCLR,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_TABCLR: begin
        cmd_o.tab_step    = 1'b1;
        cmd_o.tab_present = 1'b1;
        if (sts_i.tab_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        if (!sts_i.div_busy) begin
          if (sts_i.req_rw) begin
            state_d = S_MULT;
          end else if (sts_i.req_clear) begin
            state_d = S_EPOCH;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_MULT: begin
        cmd_o.mul_tile = 1'b1;
        state_d        = S_MULB;
      end
      S_MULB: begin
        cmd_o.mul_base = 1'b1;
        state_d        = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = S_LOOK;
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        if (sts_i.req_write && sts_i.hit_ok) begin
          state_d = sts_i.present ? S_COMMIT : S_FILL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_DONE;
      end
      S_EPOCH: begin
        if (sts_i.epoch_full) begin
          state_d = S_MARKCLR;
        end else begin
          cmd_o.epoch_adv = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_MARKCLR: begin
        cmd_o.tab_step = 1'b1;
        if (sts_i.tab_last) begin
          cmd_o.epoch_restart = 1'b1;
          state_d             = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_TABCLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== rtl/sparse_tiled_pixel_store.sv =====
// ----------------------------------------------------------------------------
// Sparse tiled pixel store
// Every request runs a bit-serial coordinate divide before its result is
// loaded. A first write to a tile zero-fills its tile_edge squared pixels
// first, and every 255th dirty clear also resets all 1024 dirty marks.
// One item is in work at a time; the next can be taken in the cycle after a
// result is loaded. After reset the tile tables are cleared with ready low.
// ----------------------------------------------------------------------------
module sparse_tiled_pixel_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  stps_pkg::stps_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output stps_pkg::stps_out_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [stps_pkg::DIM_W-1:0] cfg_wdata_i
);

  stps_pkg::stps_cmd_t cmd;
  stps_pkg::stps_sts_t sts;

  stps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stps_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/stps_checker.sv =====
// ----------------------------------------------------------------------------
// Sparse tiled pixel store checker
// Port-level assertions on the item handshakes and result fields.
// ----------------------------------------------------------------------------
module stps_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input stps_pkg::stps_out_t out_data_o
);

  // A result that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result item changed before it was taken");

  // Items are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after an accept");

  // A freshly allocated tile is always inside the image and turns dirty.
  a_alloc_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.newly_allocated |->
      out_data_o.newly_dirty && out_data_o.in_range)
    else $error("allocation without a dirty mark or outside the image");

  // Outside requests report no tile, no data and no new dirty mark.
  a_outside_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.in_range |->
      (out_data_o.read_data == '0) && (out_data_o.tile_number == '0) &&
      !out_data_o.newly_dirty)
    else $error("outside request reported tile data");

endmodule

bind sparse_tiled_pixel_store stps_checker u_stps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
